[sv/amc_pkg.sv]
// Package for the autoranging meter controller: constants, register indexes, types.
// No dependencies.
package amc_pkg;
  localparam int unsigned RdW = 34;
  localparam logic [RdW-1:0] RdMax = {RdW{1'b1}};
  localparam int unsigned CfgW = 26;
  localparam int unsigned DivW = 48;

  localparam logic [2:0] CfgFullRef  = 3'd0;
  localparam logic [2:0] CfgMidRef   = 3'd1;
  localparam logic [2:0] CfgLowRef   = 3'd2;
  localparam logic [2:0] CfgHighRes  = 3'd3;
  localparam logic [2:0] CfgMidRes   = 3'd4;
  localparam logic [2:0] CfgLowRes   = 3'd5;
  localparam logic [2:0] CfgClockHz  = 3'd6;

  localparam logic [1:0] ModeReady = 2'd0;
  localparam logic [1:0] ModeVolt  = 2'd1;
  localparam logic [1:0] ModeOhm   = 2'd2;
  localparam logic [1:0] ModeFreq  = 2'd3;

  typedef struct packed {
    logic [7:0]  adc_sample;
    logic        capture_event;
    logic [15:0] capture_count;
    logic        overflow_event;
    logic        type_press;
    logic        auto_press;
    logic        range_press;
  } req_t;

  typedef struct packed {
    logic [1:0]     mode;
    logic           auto_ranging;
    logic [1:0]     range_select;
    logic [RdW-1:0] reading;
    logic           overrange;
  } rsp_t;
endpackage

[sv/amc_if.sv]
// Valid/ready channel interface carrying one payload of type T.
// No dependencies; the payload type is given by the parameter T.
interface amc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/amc_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on amc_pkg.
module amc_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [amc_pkg::DivW-1:0] num_i,
  input  logic [amc_pkg::DivW-1:0] den_i,
  output logic                   done_o,
  output logic [amc_pkg::DivW-1:0] quo_o
);
  import amc_pkg::*;
  logic [DivW-1:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [DivW:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = {rem_q, quo_q[DivW-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0; quo_d = num_i; cnt_d = 6'(DivW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivW]) rem_d = trial[DivW-1:0];
      else rem_d = {rem_q[DivW-2:0], quo_q[DivW-1]};
      quo_d = {quo_q[DivW-2:0], ~trial[DivW]};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end
  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quo_o = quo_d;
endmodule

[sv/autoranging_meter_controller.sv]
// Top level of the autoranging meter controller: sequencer, state, config registers.
// Depends on amc_pkg, amc_if and amc_div.
//
// Usage: one request on req is one pass of the measuring loop (sample, capture
// and overflow events, button pulses). Each request yields one response on rsp
// with mode, auto flag, range, reading and overrange flag.
// Flow: a request is taken in StIdle, then passes StDiv, StFin and StOut;
// voltage, resistance and frequency requests that need a quotient also pass
// StWait on the shared 48-bit divider, one quotient bit per cycle.
// The divider loop sets the rate: one request at a time, req.ready is low
// while a request is in work and while a response is held, so a new request
// is taken only once the response to the last one has been consumed.
// Reset clears mode to ready, manual ranging, all ranges to zero, period to one
// and all stored readings to zero; config registers take calibrated defaults.
// A stalled receiver holds the response; the next request is taken once the
// response has been consumed. Config writes are taken at any edge with
// cfg_we_i high and are meant for idle periods only.
module autoranging_meter_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [amc_pkg::CfgW-1:0] cfg_data_i,
  amc_if.sink                   req,
  amc_if.source                 rsp
);
  import amc_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StWait = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] st_q, st_d;
  logic [12:0] full_q, mid_q, low_q;
  logic [19:0] rh_q, rm_q, rl_q;
  logic [25:0] clk_hz_q;
  logic [1:0] mode_q, vr_q, or_q;
  logic fr_q, auto_q, pr_q, ovp_q;
  logic [15:0] per_q;
  logic [RdW-1:0] vv_q, ov_q, fv_q;
  req_t r_q;
  rsp_t out_q;
  logic use_auto_q;

  logic div_start, div_done;
  logic [DivW-1:0] div_num, div_den, div_quo;
  logic [DivW-1:0] quo_q;

  amc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // operand selection, after capture latched into per_q / pr_q
  logic [12:0] vref;
  logic [19:0] rres;
  logic [7:0] s;
  logic [20:0] vprod;
  logic [27:0] rnum;
  logic [7:0] rden;
  logic rinf;
  logic [35:0] fnum;
  logic [18:0] fden;
  always_comb begin
    s = r_q.adc_sample;
    unique case (vr_q)
      2'd1: vref = mid_q;
      2'd2: vref = low_q;
      default: vref = full_q;
    endcase
    unique case (or_q)
      2'd1: rres = rm_q;
      2'd2: rres = rl_q;
      default: rres = rh_q;
    endcase
    vprod = 21'(s) * 21'(vref);
    rnum = 28'(rres) * 28'(s);
    rinf = (s == 8'hff) || (full_q == '0);
    rden = 8'hff - s;
    fnum = 36'(clk_hz_q) * 36'd1000;
    fden = fr_q ? {per_q, 3'b000} : {3'b000, per_q};
    div_num = '0; div_den = 48'd1;
    unique case (mode_q)
      ModeVolt: begin
        div_num = 48'(vprod) + 48'd127; div_den = 48'd255;
      end
      ModeOhm: begin
        div_num = 48'(rnum) + 48'(rden[7:1]); div_den = 48'(rden);
      end
      default: begin
        div_num = 48'(fnum) + 48'(fden[18:1]); div_den = 48'(fden);
      end
    endcase
  end

  // need a divide this pass?
  logic need_div;
  always_comb begin
    unique case (mode_q)
      ModeVolt: need_div = 1'b1;
      ModeOhm: need_div = !rinf;
      ModeFreq: need_div = (!use_auto_q || pr_q) && (fden != '0);
      default: need_div = 1'b0;
    endcase
  end

  logic [RdW-1:0] qsat;
  assign qsat = (quo_q > 48'(RdMax)) ? RdMax : quo_q[RdW-1:0];

  // resistance range compares
  logic [44:0] rn45;
  logic le30k, le3k, ge70k, ge7k;
  always_comb begin
    rn45 = 45'(rnum);
    le30k = !rinf && (rn45 <= 45'(rden) * 45'd30000);
    le3k  = !rinf && (rn45 <= 45'(rden) * 45'd3000);
    ge70k = rinf || (rn45 >= 45'(rden) * 45'd70000);
    ge7k  = rinf || (rn45 >= 45'(rden) * 45'd7000);
  end
  logic signed [22:0] vlim_mid, vlim_low, vsig;
  assign vsig = 23'(vprod);
  assign vlim_mid = (23'(mid_q) - 23'sd200) * 23'sd255;
  assign vlim_low = (23'(low_q) - 23'sd200) * 23'sd255;

  logic [1:0] mode_d, vr_d, or_d;
  logic fr_d, auto_d, pr_d, ovp_d;
  logic [15:0] per_d;
  logic [RdW-1:0] vv_d, ov_d, fv_d, fv_new;
  rsp_t out_d;
  logic [1:0] nm;

  always_comb begin
    mode_d = mode_q; vr_d = vr_q; or_d = or_q; fr_d = fr_q; auto_d = auto_q;
    pr_d = pr_q; ovp_d = ovp_q; per_d = per_q; vv_d = vv_q; ov_d = ov_q; fv_d = fv_q;
    out_d = out_q; st_d = st_q; div_start = 1'b0; fv_new = fv_q; nm = mode_q;
    unique case (st_q)
      StIdle: begin
        if (req.valid) begin
          if (req.data.capture_event) begin
            per_d = req.data.capture_count; pr_d = 1'b1;
          end
          if (req.data.overflow_event) ovp_d = 1'b1;
          st_d = StDiv;
        end
      end
      StDiv: begin
        if (need_div) begin
          div_start = 1'b1; st_d = StWait;
        end else st_d = StFin;
      end
      StWait: if (div_done) st_d = StFin;
      StFin: begin
        if (mode_q != ModeReady && r_q.auto_press) auto_d = ~auto_q;
        unique case (mode_q)
          ModeVolt: begin
            vv_d = qsat;
            if (use_auto_q) begin
              priority case (vr_q)
                2'd1: if (vsig <= vlim_low) vr_d = 2'd2;
                      else if (s == 8'hff) vr_d = 2'd0;
                2'd2: if (s == 8'hff) vr_d = 2'd1;
                default: if (vsig <= vlim_mid) vr_d = 2'd1;
              endcase
            end else if (r_q.range_press) vr_d = (vr_q >= 2'd2) ? 2'd0 : vr_q + 2'd1;
          end
          ModeOhm: begin
            ov_d = rinf ? RdMax : qsat;
            if (use_auto_q) begin
              priority case (or_q)
                2'd1: if (le3k) or_d = 2'd2;
                      else if (ge70k) or_d = 2'd0;
                2'd2: if (ge7k) or_d = 2'd1;
                default: if (le30k) or_d = 2'd1;
              endcase
            end else if (r_q.range_press) or_d = (or_q >= 2'd2) ? 2'd0 : or_q + 2'd1;
          end
          ModeFreq: begin
            fv_new = (fden == '0) ? RdMax : qsat;
            if (use_auto_q) begin
              if (pr_q) fv_d = fv_new;
              if (!fr_q) begin
                if (ovp_q) begin
                  ovp_d = 1'b0; fr_d = 1'b1; pr_d = 1'b0;
                end
              end else if (fv_d > 34'd400000) begin
                fr_d = 1'b0; pr_d = 1'b0;
              end
            end else begin
              fv_d = fv_new;
              if (r_q.range_press) fr_d = ~fr_q;
            end
          end
          default: ;
        endcase
        if (r_q.type_press) begin
          nm = mode_q + 2'd1;
          mode_d = nm;
          if (nm != ModeReady) auto_d = 1'b0;
          if (nm == ModeFreq) per_d = 16'd1;
        end
        out_d.mode = mode_d;
        out_d.auto_ranging = auto_d;
        unique case (mode_d)
          ModeVolt: begin out_d.range_select = vr_d; out_d.reading = vv_d; end
          ModeOhm: begin out_d.range_select = or_d; out_d.reading = ov_d; end
          ModeFreq: begin out_d.range_select = {1'b0, fr_d}; out_d.reading = fv_d; end
          default: begin out_d.range_select = 2'd0; out_d.reading = '0; end
        endcase
        out_d.overrange = (out_d.reading == RdMax);
        st_d = StOut;
      end
      StOut: if (rsp.ready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign req.ready = (st_q == StIdle);
  assign rsp.valid = (st_q == StOut);
  assign rsp.data = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      full_q <= 13'd5030; mid_q <= 13'd2540; low_q <= 13'd1100;
      rh_q <= 20'd92900; rm_q <= 20'd9950; rl_q <= 20'd993;
      clk_hz_q <= 26'd16000000;
      mode_q <= ModeReady; auto_q <= 1'b0; vr_q <= '0; or_q <= '0; fr_q <= 1'b0;
      per_q <= 16'd1; pr_q <= 1'b0; ovp_q <= 1'b0;
      vv_q <= '0; ov_q <= '0; fv_q <= '0;
    end else begin
      st_q <= st_d;
      mode_q <= mode_d; auto_q <= auto_d; vr_q <= vr_d; or_q <= or_d; fr_q <= fr_d;
      per_q <= per_d; pr_q <= pr_d; ovp_q <= ovp_d;
      vv_q <= vv_d; ov_q <= ov_d; fv_q <= fv_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgFullRef: full_q <= cfg_data_i[12:0];
          CfgMidRef:  mid_q <= cfg_data_i[12:0];
          CfgLowRef:  low_q <= cfg_data_i[12:0];
          CfgHighRes: rh_q <= cfg_data_i[19:0];
          CfgMidRes:  rm_q <= cfg_data_i[19:0];
          CfgLowRes:  rl_q <= cfg_data_i[19:0];
          CfgClockHz: clk_hz_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (div_done) quo_q <= div_quo;
    if (st_q == StIdle && req.valid) begin
      r_q <= req.data;
      use_auto_q <= auto_q;
    end
  end
endmodule

[dv/autoranging_meter_controller_tb.sv]
// Self-checking testbench for autoranging_meter_controller: a queue-fed driver,
// a response monitor and an in-bench predictor of mode, range and reading.
// Depends on amc_pkg, amc_if and the controller RTL.
module autoranging_meter_controller_tb;
  import amc_pkg::*;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [2:0]      cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  amc_if #(.T(req_t)) req_if ();
  amc_if #(.T(rsp_t)) rsp_if ();

  autoranging_meter_controller u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  // predictor copies of the registers and state
  logic [12:0] m_full_ref, m_mid_ref, m_low_ref;
  logic [19:0] m_high_res, m_mid_res, m_low_res;
  logic [25:0] m_clock_hz;
  logic [1:0]  m_mode, m_volt_rng, m_ohm_rng;
  logic        m_auto, m_freq_rng, m_period_rdy, m_ovf_pend;
  logic [15:0] m_period;
  logic [RdW-1:0] m_volt_val, m_ohm_val, m_freq_val;

  req_t pending_req_q[$];
  rsp_t expected_rsp_q[$];
  int unsigned issued_cnt, done_cnt, err_cnt;
  int unsigned req_gap, rsp_gap;
  bit idle_en, long_hold;
  bit req_fire;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("autoranging_meter_controller_tb: errors");
    $finish;
  end

  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    longint unsigned q;
    if (d == 0) return longint'(RdMax);
    q = (n + d / 2) / d;
    return (q > longint'(RdMax)) ? longint'(RdMax) : q;
  endfunction

  function automatic logic [RdW-1:0] period_to_mhz();
    longint unsigned d;
    d = longint'(m_period) * (m_freq_rng ? 8 : 1);
    return RdW'(round_div(longint'(m_clock_hz) * 1000, d));
  endfunction

  function automatic rsp_t predict_pass(req_t r);
    rsp_t o;
    longint unsigned s, refv, num, den, res;
    longint signed v;
    bit use_auto, inf, le30k, le3k, ge70k, ge7k;
    s = r.adc_sample;
    use_auto = m_auto;
    if (r.capture_event) begin
      m_period = r.capture_count;
      m_period_rdy = 1'b1;
    end
    if (r.overflow_event) m_ovf_pend = 1'b1;
    if (m_mode != ModeReady) begin
      if (r.auto_press) m_auto = ~m_auto;
      if (m_mode == ModeVolt) begin
        refv = (m_volt_rng == 1) ? m_mid_ref : ((m_volt_rng == 2) ? m_low_ref : m_full_ref);
        v = longint'(s * refv);
        m_volt_val = RdW'((s * refv + 127) / 255);
        if (use_auto) begin
          if (m_volt_rng == 1) begin
            if (v <= (longint'(m_low_ref) - 200) * 255) m_volt_rng = 2;
            else if (s == 255) m_volt_rng = 0;
          end else if (m_volt_rng == 2) begin
            if (s == 255) m_volt_rng = 1;
          end else begin
            if (v <= (longint'(m_mid_ref) - 200) * 255) m_volt_rng = 1;
          end
        end else if (r.range_press) begin
          m_volt_rng = (m_volt_rng >= 2) ? 2'd0 : m_volt_rng + 2'd1;
        end
      end else if (m_mode == ModeOhm) begin
        res = (m_ohm_rng == 1) ? m_mid_res : ((m_ohm_rng == 2) ? m_low_res : m_high_res);
        inf = (s == 255) || (m_full_ref == 0);
        den = inf ? 0 : 255 - s;
        num = res * s;
        m_ohm_val = inf ? RdMax : RdW'(round_div(num, den));
        if (use_auto) begin
          le30k = !inf && num <= 30000 * den;
          le3k  = !inf && num <= 3000 * den;
          ge70k = inf || num >= 70000 * den;
          ge7k  = inf || num >= 7000 * den;
          if (m_ohm_rng == 1) begin
            if (le3k) m_ohm_rng = 2;
            else if (ge70k) m_ohm_rng = 0;
          end else if (m_ohm_rng == 2) begin
            if (ge7k) m_ohm_rng = 1;
          end else begin
            if (le30k) m_ohm_rng = 1;
          end
        end else if (r.range_press) begin
          m_ohm_rng = (m_ohm_rng >= 2) ? 2'd0 : m_ohm_rng + 2'd1;
        end
      end else begin
        if (use_auto) begin
          if (!m_freq_rng) begin
            if (m_period_rdy) m_freq_val = period_to_mhz();
            if (m_ovf_pend) begin
              m_ovf_pend = 1'b0;
              m_freq_rng = 1'b1;
              m_period_rdy = 1'b0;
            end
          end else begin
            if (m_period_rdy) m_freq_val = period_to_mhz();
            if (m_freq_val > 400000) begin
              m_freq_rng = 1'b0;
              m_period_rdy = 1'b0;
            end
          end
        end else begin
          m_freq_val = period_to_mhz();
          if (r.range_press) m_freq_rng = ~m_freq_rng;
        end
      end
    end
    if (r.type_press) begin
      m_mode = m_mode + 2'd1;
      if (m_mode != ModeReady) m_auto = 1'b0;
      if (m_mode == ModeFreq) m_period = 16'd1;
    end
    o = '0;
    o.mode = m_mode;
    o.auto_ranging = m_auto;
    case (m_mode)
      ModeVolt: begin
        o.range_select = m_volt_rng;
        o.reading = m_volt_val;
      end
      ModeOhm: begin
        o.range_select = m_ohm_rng;
        o.reading = m_ohm_val;
      end
      ModeFreq: begin
        o.range_select = {1'b0, m_freq_rng};
        o.reading = m_freq_val;
      end
      default: ;
    endcase
    o.overrange = (o.reading == RdMax);
    return o;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // request taken at the last rising edge
  always @(posedge clk_i) begin
    req_fire <= req_if.valid && req_if.ready;
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && !req_fire) begin
      end else if (req_gap > 0) begin
        req_gap <= req_gap - 1;
        req_if.valid <= 1'b0;
      end else if (pending_req_q.size() > 0) begin
        req_if.data <= pending_req_q.pop_front();
        req_if.valid <= 1'b1;
        req_gap <= idle_en ? pick_gap() : 0;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_hold) begin
        long_hold <= 1'b0;
        rsp_gap <= 400;
        rsp_if.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) rsp_gap <= pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t want, got;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) expected_rsp_q.push_back(predict_pass(req_if.data));
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        done_cnt <= done_cnt + 1;
        if (expected_rsp_q.size() == 0) begin
          $error("unexpected response %p", got);
          err_cnt++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.mode !== want.mode) begin
            $error("mode exp %0d got %0d", want.mode, got.mode);
            err_cnt++;
          end
          if (got.auto_ranging !== want.auto_ranging) begin
            $error("auto_ranging exp %0d got %0d", want.auto_ranging, got.auto_ranging);
            err_cnt++;
          end
          if (got.range_select !== want.range_select) begin
            $error("range_select exp %0d got %0d", want.range_select, got.range_select);
            err_cnt++;
          end
          if (got.reading !== want.reading) begin
            $error("reading exp %0d got %0d", want.reading, got.reading);
            err_cnt++;
          end
          if (got.overrange !== want.overrange) begin
            $error("overrange exp %0d got %0d", want.overrange, got.overrange);
            err_cnt++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgFullRef: m_full_ref = val[12:0];
      CfgMidRef:  m_mid_ref  = val[12:0];
      CfgLowRef:  m_low_ref  = val[12:0];
      CfgHighRes: m_high_res = val[19:0];
      CfgMidRes:  m_mid_res  = val[19:0];
      CfgLowRes:  m_low_res  = val[19:0];
      default:    m_clock_hz = val[25:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [12:0] f, logic [12:0] m, logic [12:0] l,
                           logic [19:0] rh, logic [19:0] rm, logic [19:0] rl,
                           logic [25:0] hz);
    write_reg(CfgFullRef, CfgW'(f));
    write_reg(CfgMidRef, CfgW'(m));
    write_reg(CfgLowRef, CfgW'(l));
    write_reg(CfgHighRes, CfgW'(rh));
    write_reg(CfgMidRes, CfgW'(rm));
    write_reg(CfgLowRes, CfgW'(rl));
    write_reg(CfgClockHz, CfgW'(hz));
  endtask

  task automatic queue_req(req_t r);
    pending_req_q.push_back(r);
    issued_cnt++;
  endtask

  task automatic drain();
    do @(negedge clk_i); while (done_cnt != issued_cnt || pending_req_q.size() != 0);
    repeat (70) @(negedge clk_i);
  endtask

  function automatic req_t make_req(logic [7:0] s, bit tp, bit ap, bit rp, bit ce,
                                    logic [15:0] cc, bit ov);
    req_t r;
    r.adc_sample = s;
    r.type_press = tp;
    r.auto_press = ap;
    r.range_press = rp;
    r.capture_event = ce;
    r.capture_count = cc;
    r.overflow_event = ov;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int unsigned p;
    p = $urandom_range(0, 9);
    r.adc_sample = (p == 0) ? 8'd0 : ((p == 1) ? 8'd255 : 8'($urandom));
    p = $urandom_range(0, 9);
    r.capture_count = (p == 0) ? 16'd0 : ((p == 1) ? 16'($urandom_range(1, 8)) :
                      ((p == 2) ? 16'hffff : 16'($urandom)));
    r.capture_event = ($urandom_range(0, 9) < 3);
    r.overflow_event = ($urandom_range(0, 9) < 2);
    r.type_press = ($urandom_range(0, 99) < 6);
    r.auto_press = ($urandom_range(0, 99) < 12);
    r.range_press = ($urandom_range(0, 99) < 20);
    return r;
  endfunction

  task automatic random_phase(int unsigned n);
    repeat (n) queue_req(rand_req());
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    issued_cnt = 0;
    done_cnt = 0;
    err_cnt = 0;
    req_gap = 0;
    rsp_gap = 0;
    idle_en = 1'b1;
    long_hold = 1'b0;
    req_fire = 1'b0;
    m_full_ref = 13'd5030; m_mid_ref = 13'd2540; m_low_ref = 13'd1100;
    m_high_res = 20'd92900; m_mid_res = 20'd9950; m_low_res = 20'd993;
    m_clock_hz = 26'd16000000;
    m_mode = ModeReady; m_auto = 1'b0; m_volt_rng = '0; m_ohm_rng = '0;
    m_freq_rng = 1'b0; m_period = 16'd1; m_period_rdy = 1'b0; m_ovf_pend = 1'b0;
    m_volt_val = '0; m_ohm_val = '0; m_freq_val = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // presses in ready mode are dropped; then walk every mode
    queue_req(make_req(8'd255, 0, 1, 1, 0, 16'd0, 0));
    queue_req(make_req(8'd0, 1, 0, 0, 0, 16'd0, 0));
    queue_req(make_req(8'd255, 0, 0, 1, 0, 16'd0, 0));
    queue_req(make_req(8'd0, 0, 1, 1, 0, 16'd0, 0));
    queue_req(make_req(8'd1, 0, 0, 1, 0, 16'd0, 0));
    queue_req(make_req(8'd255, 0, 0, 0, 0, 16'd0, 0));
    queue_req(make_req(8'd255, 0, 0, 0, 0, 16'd0, 0));
    queue_req(make_req(8'd128, 1, 0, 0, 0, 16'd0, 0));
    queue_req(make_req(8'd255, 0, 0, 1, 0, 16'd0, 0));
    queue_req(make_req(8'd0, 0, 1, 0, 0, 16'd0, 0));
    queue_req(make_req(8'd254, 0, 0, 0, 0, 16'd0, 0));
    queue_req(make_req(8'd255, 0, 0, 0, 0, 16'd0, 0));
    queue_req(make_req(8'd1, 0, 0, 0, 0, 16'd0, 0));
    queue_req(make_req(8'd0, 1, 0, 0, 1, 16'hffff, 1));
    queue_req(make_req(8'd0, 0, 0, 0, 1, 16'd0, 0));
    queue_req(make_req(8'd0, 0, 0, 1, 1, 16'hffff, 0));
    queue_req(make_req(8'd0, 0, 1, 0, 1, 16'd1, 0));
    queue_req(make_req(8'd0, 0, 0, 0, 0, 16'd0, 1));
    queue_req(make_req(8'd0, 0, 0, 0, 1, 16'd3, 0));
    queue_req(make_req(8'd0, 0, 0, 0, 1, 16'd50000, 0));
    queue_req(make_req(8'd0, 1, 0, 0, 0, 16'd0, 0));
    drain();
    random_phase(150);

    write_all(13'd0, 13'd0, 13'd0, 20'd0, 20'd0, 20'd0, 26'd1);
    random_phase(150);

    write_all(13'h1fff, 13'h1fff, 13'h1fff, 20'hfffff, 20'hfffff, 20'hfffff, 26'h3ffffff);
    random_phase(150);

    // long receiver hold while requests keep coming
    write_all(13'($urandom), 13'($urandom), 13'($urandom), 20'($urandom),
              20'($urandom), 20'($urandom), 26'($urandom_range(1, 26'h3ffffff)));
    queue_req(make_req(8'd0, 1, 0, 0, 0, 16'd0, 0));
    long_hold = 1'b1;
    random_phase(150);

    idle_en = 1'b0;
    write_all(13'd5030, 13'd2540, 13'd1100, 20'd92900, 20'd9950, 20'd993, 26'd16000000);
    random_phase(150);
    idle_en = 1'b1;

    write_all(13'd8191, 13'd150, 13'd300, 20'd1, 20'd1048575, 20'd7000, 26'd100);
    random_phase(150);

    write_all(13'($urandom), 13'($urandom), 13'($urandom), 20'($urandom),
              20'($urandom), 20'($urandom), 26'($urandom_range(1, 26'h3ffffff)));
    random_phase(150);

    if (err_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("autoranging_meter_controller_tb: clean");
    end else begin
      $display("autoranging_meter_controller_tb: errors");
    end
    $finish;
  end
endmodule

[filelist.f]
sv/amc_pkg.sv
sv/amc_if.sv
sv/amc_div.sv
sv/autoranging_meter_controller.sv
dv/autoranging_meter_controller_tb.sv
